>>> hdl/bdq_pkg.sv
// Shared types and constants for the bounded deque with indexed read.
// Holds action codes, controller states and the controller/datapath link structs.
// No dependencies.
`default_nettype none

package bdq_pkg;

  // Default sizing of the element store.
  localparam int unsigned DEF_CAPACITY      = 256;
  localparam int unsigned DEF_ELEMENT_WIDTH = 32;

  // Field widths fixed by the stream interface.
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned IN_DATA_W = 48;
  localparam int unsigned OUT_DATA_W = 112;

  // Action codes; codes above the last one behave as no action.
  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE     = 3'd0,
    ACT_INS_HEAD = 3'd1,
    ACT_INS_TAIL = 3'd2,
    ACT_REM_HEAD = 3'd3,
    ACT_REM_TAIL = 3'd4
  } action_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_HEAD,
    ST_RD_TAIL,
    ST_RD_POS,
    ST_RD_LAST,
    ST_DONE
  } state_t;

  // Which queue position the store read port looks at.
  typedef enum logic [1:0] {
    RSEL_HEAD,
    RSEL_TAIL,
    RSEL_POS
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    logic    exec;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_head;
    logic    cap_tail;
    logic    cap_pos;
    logic    load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/bdq_ctrl.sv
// Controller state machine for the bounded deque.
// Sequences update, three store reads and result hand-off; depends on bdq_pkg.
`default_nettype none

module bdq_ctrl
  import bdq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_EXEC;
      ST_EXEC:    state_next = ST_RD_HEAD;
      ST_RD_HEAD: state_next = ST_RD_TAIL;
      ST_RD_TAIL: state_next = ST_RD_POS;
      ST_RD_POS:  state_next = ST_RD_LAST;
      ST_RD_LAST: state_next = ST_DONE;
      ST_DONE:    if (status.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    cmd      = '0;
    cmd.rd_sel = RSEL_HEAD;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_RD_HEAD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RSEL_HEAD;
      end
      ST_RD_TAIL: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RSEL_TAIL;
        cmd.cap_head = 1'b1;
      end
      ST_RD_POS: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RSEL_POS;
        cmd.cap_tail = 1'b1;
      end
      ST_RD_LAST: begin
        cmd.cap_pos = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/bdq_datapath.sv
// Datapath of the bounded deque: ring pointers, element store and result register.
// Driven by bdq_ctrl commands; depends on bdq_pkg.
`default_nettype none

module bdq_datapath
  import bdq_pkg::*;
#(
  parameter int unsigned CAPACITY      = DEF_CAPACITY,
  parameter int unsigned ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             cmd,
  output dp_status_t               status,
  input  wire logic [ACTION_W-1:0] action,
  input  wire logic [ELEM_W-1:0]   element,
  input  wire logic [POS_W-1:0]    position,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_accepted,
  output logic [COUNT_W-1:0]       out_count,
  output logic [ELEM_W-1:0]        out_head,
  output logic [ELEM_W-1:0]        out_tail,
  output logic [ELEM_W-1:0]        out_read,
  output logic                     out_read_valid
);

  localparam int unsigned PW     = $clog2(CAPACITY);
  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = CW + POS_W;
  localparam int unsigned STORE_W = (ELEMENT_WIDTH < ELEM_W) ? ELEMENT_WIDTH : ELEM_W;
  localparam logic [PW:0]   CAP_P  = (PW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [PW-1:0] LAST_SLOT = PW'(CAPACITY - 1);

  // Ring slot of an offset from the head, offset below the capacity.
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] hp,
                                            input logic [PW-1:0] off);
    logic [PW:0] s;
    s = {1'b0, hp} + {1'b0, off};
    if (s >= CAP_P) s = s - CAP_P;
    return s[PW-1:0];
  endfunction

  // Latched input word.
  action_t             act_q;
  logic [STORE_W-1:0]  elem_q;
  logic [POS_W-1:0]    pos_q;

  // Queue state.
  logic [PW-1:0]       head_ptr;
  logic [PW-1:0]       head_ptr_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                acc_q;
  logic                acc_next;

  // Store write port.
  logic                we;
  logic [PW-1:0]       waddr;
  logic [STORE_W-1:0]  mem [CAPACITY];
  logic [PW-1:0]       raddr;
  logic [STORE_W-1:0]  rdata;

  // Captured reads.
  logic [STORE_W-1:0]  head_q;
  logic [STORE_W-1:0]  tail_q;
  logic [STORE_W-1:0]  pos_data_q;
  logic                pos_ok;

  // Take the input word.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_q  <= action_t'(action);
      elem_q <= element[STORE_W-1:0];
      pos_q  <= position;
    end
  end

  // Action decode and pointer update.
  always_comb begin
    head_ptr_next = head_ptr;
    count_next    = count;
    acc_next      = 1'b1;
    we            = 1'b0;
    waddr         = slot_of(head_ptr, PW'(count));
    if (act_q == ACT_INS_HEAD || act_q == ACT_INS_TAIL) begin
      if (count == CAP_C) begin
        acc_next = 1'b0;
      end else begin
        we         = 1'b1;
        count_next = count + CW'(1);
        if (act_q == ACT_INS_HEAD) begin
          head_ptr_next = (head_ptr == '0) ? LAST_SLOT : head_ptr - PW'(1);
          waddr         = head_ptr_next;
        end
      end
    end else if (act_q == ACT_REM_HEAD || act_q == ACT_REM_TAIL) begin
      if (count == '0) begin
        acc_next = 1'b0;
      end else begin
        count_next = count - CW'(1);
        if (act_q == ACT_REM_HEAD) head_ptr_next = slot_of(head_ptr, PW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      count    <= '0;
    end else if (cmd.exec) begin
      head_ptr <= head_ptr_next;
      count    <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) acc_q <= acc_next;
  end

  // Element store, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.exec && we) mem[waddr] <= elem_q;
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RSEL_HEAD: raddr = head_ptr;
      RSEL_TAIL: raddr = slot_of(head_ptr, PW'(count - CW'(1)));
      RSEL_POS:  raddr = slot_of(head_ptr, PW'(pos_q));
      default:   raddr = head_ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdata <= mem[raddr];
  end

  // Capture the three reads as they arrive.
  always_ff @(posedge clk) begin
    if (cmd.cap_head) head_q     <= rdata;
    if (cmd.cap_tail) tail_q     <= rdata;
    if (cmd.cap_pos)  pos_data_q <= rdata;
  end

  assign pos_ok = CMP_W'(pos_q) < CMP_W'(count);

  // Result register, free when empty or being drained.
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_accepted   <= acc_q;
      out_count      <= COUNT_W'(count);
      out_head       <= (count != '0) ? ELEM_W'(head_q) : '0;
      out_tail       <= (count != '0) ? ELEM_W'(tail_q) : '0;
      out_read       <= pos_ok ? ELEM_W'(pos_data_q) : '0;
      out_read_valid <= pos_ok;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bounded_deque_with_indexed_read.sv
// Bounded deque with indexed read: the user takes one item per input word and gets one result word.
// Each accepted word runs through the update of the ring pointers and store, then three reads of
// the store's single read port (head, tail and the requested position), each registered, then the
// load of the result register. A new word is taken only once the previous one's load is done. The
// load waits for as long as an earlier result still sits unread in the result register.
// The input accepts a new word while the previous result still waits on the output side.
// The element store needs no clearing pass after reset; only written entries are ever reported.
// Depends on bdq_pkg, bdq_ctrl and bdq_datapath.
`default_nettype none

module bounded_deque_with_indexed_read
  import bdq_pkg::*;
#(
  parameter int unsigned CAPACITY      = DEF_CAPACITY,
  parameter int unsigned ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // action [2:0], element [34:3], position [42:35], zeros [47:43]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // accepted [0], count [9:1], head_element [41:10], tail_element [73:42],
  // read_element [105:74], read_valid [106], zeros [111:107]
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  dp_cmd_t              cmd;
  dp_status_t           status;
  logic                 out_accepted;
  logic [COUNT_W-1:0]   out_count;
  logic [ELEM_W-1:0]    out_head;
  logic [ELEM_W-1:0]    out_tail;
  logic [ELEM_W-1:0]    out_read;
  logic                 out_read_valid;

  // Sequencer.
  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Pointers, store and result register.
  bdq_datapath #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .action         (s_tdata[2:0]),
    .element        (s_tdata[34:3]),
    .position       (s_tdata[42:35]),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_accepted   (out_accepted),
    .out_count      (out_count),
    .out_head       (out_head),
    .out_tail       (out_tail),
    .out_read       (out_read),
    .out_read_valid (out_read_valid)
  );

  // Pack the result word.
  assign m_tdata = {5'd0, out_read_valid, out_read, out_tail, out_head, out_count,
                    out_accepted};

  // An accepted word keeps the input closed on the following cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted twice in succession");

  // An invalid indexed read reports a zero element.
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[106]) |-> (m_tdata[105:74] == '0))
    else $error("invalid read carries a non-zero element");

  // The reported count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((CAPACITY >= 512) || (m_tdata[9:1] <= COUNT_W'(CAPACITY))))
    else $error("reported count above capacity");

  // An empty queue reports zero head and tail and no valid read.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (CAPACITY < 512) && (m_tdata[9:1] == '0)) |->
      ((m_tdata[41:10] == '0) && (m_tdata[73:42] == '0) && !m_tdata[106]))
    else $error("empty queue reports elements");

endmodule

`default_nettype wire
